@@ design/iftb_pkg.sv @@
// Package for the IPv4 flow tuple batcher: codes, widths and shared types.
// No dependencies.
package iftb_pkg;

    localparam int DefMaxSequences    = 128;
    localparam int DefMaxPacketsPerSeq = 128;

    localparam logic [15:0] EthArp  = 16'h0806;
    localparam logic [15:0] EthIpv4 = 16'h0800;
    localparam logic [7:0]  ProtoIcmp = 8'd1;
    localparam logic [7:0]  ProtoTcp  = 8'd6;
    localparam logic [7:0]  ProtoUdp  = 8'd17;
    localparam logic [17:0] MinIpHeader = 18'd20;
    localparam logic [17:0] L4Header    = 18'd8;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] RegIpv4 = 2'd0;
    localparam logic [CfgIdxW-1:0] RegIcmp = 2'd1;
    localparam logic [CfgIdxW-1:0] RegTcp  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegUdp  = 2'd3;

    typedef enum logic [2:0] {
        D_BATCHED   = 3'd0,
        D_ARP       = 3'd1,
        D_ICMP      = 3'd2,
        D_MALFORMED = 3'd3,
        D_OTHER     = 3'd4,
        D_ICMP_OFF  = 3'd5,
        D_IPV4_OFF  = 3'd6,
        D_FLUSHED   = 3'd7
    } disp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        command;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [15:0] l3_length;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } req_t;

    typedef struct packed {
        logic [2:0] disposition;
        logic [6:0] seq_index;
        logic       new_sequence;
        logic [7:0] seq_fill;
        logic       deliver;
        logic       batch_full;
        logic       source_changed;
    } rsp_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic               data;
    } cfg_t;

endpackage

@@ design/iftb_if.sv @@
// Valid/ready channel interfaces for the flow batcher.
// Depends on iftb_pkg.
interface iftb_req_if;
    logic           valid;
    logic           ready;
    iftb_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface iftb_rsp_if;
    logic           valid;
    logic           ready;
    iftb_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface iftb_cfg_if;
    logic           valid;
    logic           ready;
    iftb_pkg::cfg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/iftb_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module iftb_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

@@ design/iftb_classify.sv @@
// Header checks of one frame request: steers, drops or passes it to the lookup.
// Depends on iftb_pkg.
module iftb_classify (
    input  iftb_pkg::req_t req,
    input  logic           ipv4_en,
    input  logic           icmp_en,
    input  logic [31:0]    last_src,
    output logic           to_lookup,
    output logic [2:0]     disp,
    output logic           src_update
);

    logic [17:0] hlen;
    logic [17:0] l3;
    logic        header_ok;

    assign hlen = {12'd0, req.header_words, 2'b00};
    assign l3   = {2'b00, req.l3_length};
    assign header_ok = (hlen >= iftb_pkg::MinIpHeader) && (req.total_length == req.l3_length)
                       && (hlen <= l3);

    always_comb
    begin
        to_lookup  = 1'b0;
        src_update = 1'b0;
        disp       = iftb_pkg::D_BATCHED;
        if (req.command)
        begin
            disp = iftb_pkg::D_FLUSHED;
        end
        else if (!ipv4_en)
        begin
            disp = iftb_pkg::D_IPV4_OFF;
        end
        else if (req.ether_type == iftb_pkg::EthArp)
        begin
            disp = iftb_pkg::D_ARP;
        end
        else if (req.ether_type != iftb_pkg::EthIpv4)
        begin
            disp = iftb_pkg::D_OTHER;
        end
        else if (!header_ok)
        begin
            disp = iftb_pkg::D_MALFORMED;
        end
        else
        begin
            src_update = (req.src_addr != 32'd0) && (req.src_addr != last_src);
            if (req.protocol == iftb_pkg::ProtoIcmp)
            begin
                disp = icmp_en ? iftb_pkg::D_ICMP : iftb_pkg::D_ICMP_OFF;
            end
            else if ((l3 - hlen) < iftb_pkg::L4Header)
            begin
                disp = iftb_pkg::D_MALFORMED;
            end
            else if (req.protocol != iftb_pkg::ProtoTcp && req.protocol != iftb_pkg::ProtoUdp)
            begin
                disp = iftb_pkg::D_OTHER;
            end
            else
            begin
                to_lookup = 1'b1;
            end
        end
    end

endmodule

@@ design/ipv4_flow_tuple_batcher.sv @@
// Top level of the IPv4 flow tuple batcher.
// Flow (request taken to result valid): a request that is not batched goes from ISSUE
//   to DONE; a batched packet reads the open sequences (newest first) through one table
//   RAM port, each read in ISSUE and compared in CHECK, at most MaxSequences-1 of them,
//   then goes to WRITE and DONE. One request at a time; the next is taken once the result is accepted.
// Reset: asynchronous, active low; clears the open count, last source and sets
//   every enable; table contents need no clearing (only slots below the count are read).
// Depends on iftb_pkg, iftb_if, iftb_ram, iftb_classify.
module ipv4_flow_tuple_batcher #(
    parameter int MaxSequences    = iftb_pkg::DefMaxSequences,
    parameter int MaxPacketsPerSeq = iftb_pkg::DefMaxPacketsPerSeq
) (
    input  logic        clk,
    input  logic        rst_n,
    iftb_req_if.sink    req,
    iftb_rsp_if.source  rsp,
    iftb_cfg_if.sink    cfg
);

    localparam int AW = $clog2(MaxSequences);
    localparam int CW = $clog2(MaxSequences + 1);
    localparam int PW = $clog2(MaxPacketsPerSeq + 1);
    localparam int EW = 64 + 40 + PW;
    localparam logic [CW-1:0] SeqMax  = CW'(MaxSequences);
    localparam logic [PW-1:0] PktMax  = PW'(MaxPacketsPerSeq);

    iftb_pkg::state_t state_reg, state_next;

    iftb_pkg::req_t req_reg;
    iftb_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    logic ipv4_en_reg, icmp_en_reg, tcp_en_reg, udp_en_reg;
    logic [31:0]   last_src_reg, last_src_next;
    logic [CW-1:0] open_reg, open_next;
    logic [CW-1:0] scan_reg, scan_next;   // slots still to scan, newest first
    logic [AW-1:0] idx_reg, idx_next;
    logic          fresh_reg, fresh_next;
    logic          changed_reg, changed_next;   // source recorded for this request

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic          to_lookup, src_update;
    logic [2:0]    cls_disp;
    logic [63:0]   akey;
    logic [39:0]   pkey;
    logic [PW-1:0] hit_count, new_count;
    logic          hit;

    // Configuration: take writes at any time, ignore indices off the list.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_en_reg <= 1'b1;
            icmp_en_reg <= 1'b1;
            tcp_en_reg  <= 1'b1;
            udp_en_reg  <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                iftb_pkg::RegIpv4: ipv4_en_reg <= cfg.payload.data;
                iftb_pkg::RegIcmp: icmp_en_reg <= cfg.payload.data;
                iftb_pkg::RegTcp:  tcp_en_reg  <= cfg.payload.data;
                iftb_pkg::RegUdp:  udp_en_reg  <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    iftb_classify u_classify (
        .req        (req_reg),
        .ipv4_en    (ipv4_en_reg),
        .icmp_en    (icmp_en_reg),
        .last_src   (last_src_reg),
        .to_lookup  (to_lookup),
        .disp       (cls_disp),
        .src_update (src_update)
    );

    // One entry holds addresses, protocol/ports and packet count.
    iftb_ram #(.Width(EW), .Depth(MaxSequences)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign akey = {req_reg.src_addr, req_reg.dst_addr};
    assign pkey = {req_reg.protocol, req_reg.src_port, req_reg.dst_port};
    assign hit_count = ram_rdata[PW-1:0];
    assign hit = (ram_rdata[EW-1 -: 64] == akey) && (ram_rdata[PW +: 40] == pkey);
    assign new_count = fresh_reg ? PW'(1) : hit_count + PW'(1);

    assign req.ready = (state_reg == iftb_pkg::S_IDLE) && !rsp_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iftb_pkg::S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    state_next = iftb_pkg::S_ISSUE;
                end
            end
            iftb_pkg::S_ISSUE:
            begin
                if (!to_lookup)          state_next = iftb_pkg::S_DONE;
                else if (scan_reg == '0) state_next = iftb_pkg::S_WRITE;
                else                     state_next = iftb_pkg::S_CHECK;
            end
            iftb_pkg::S_CHECK:
            begin
                if (hit || scan_reg == '0) state_next = iftb_pkg::S_WRITE;
                else                       state_next = iftb_pkg::S_ISSUE;
            end
            iftb_pkg::S_WRITE: state_next = iftb_pkg::S_DONE;
            iftb_pkg::S_DONE:  state_next = iftb_pkg::S_IDLE;
            default:           state_next = iftb_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        open_next      = open_reg;
        last_src_next  = last_src_reg;
        scan_next      = scan_reg;
        idx_next       = idx_reg;
        fresh_next     = fresh_reg;
        changed_next   = changed_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_addr       = idx_reg;
        ram_wdata      = {akey, pkey, new_count};
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            iftb_pkg::S_IDLE:
            begin
                scan_next    = open_reg;
                fresh_next   = 1'b0;
                changed_next = 1'b0;
            end
            iftb_pkg::S_ISSUE:
            begin
                // Read the next older slot; when the scan is exhausted, open a new one.
                if (scan_reg != '0)
                begin
                    scan_next = scan_reg - CW'(1);
                    idx_next  = AW'(scan_reg - CW'(1));
                    ram_addr  = AW'(scan_reg - CW'(1));
                end
                else
                begin
                    fresh_next = 1'b1;
                    idx_next   = (open_reg >= SeqMax) ? AW'(MaxSequences - 1) : AW'(open_reg);
                end
                if (src_update)
                begin
                    last_src_next = req_reg.src_addr;
                    changed_next  = 1'b1;
                end
            end
            iftb_pkg::S_CHECK:
            begin
                if (hit && hit_count >= PktMax)
                begin
                    fresh_next = 1'b1;
                    idx_next   = (open_reg >= SeqMax) ? AW'(MaxSequences - 1) : AW'(open_reg);
                end
                else if (!hit && scan_reg == '0)
                begin
                    fresh_next = 1'b1;
                    idx_next   = (open_reg >= SeqMax) ? AW'(MaxSequences - 1) : AW'(open_reg);
                end
            end
            iftb_pkg::S_WRITE:
            begin
                ram_we = 1'b1;
                rsp_next.disposition    = iftb_pkg::D_BATCHED;
                rsp_next.seq_index      = 7'(idx_reg);
                rsp_next.new_sequence   = fresh_reg;
                rsp_next.seq_fill       = 8'(new_count);
                rsp_next.deliver        = (req_reg.protocol == iftb_pkg::ProtoTcp) ?
                                          tcp_en_reg : udp_en_reg;
                rsp_next.batch_full     = 1'b0;
                rsp_next.source_changed = changed_reg;
                if (fresh_reg)
                begin
                    open_next = CW'(idx_reg) + CW'(1);
                end
                if (fresh_reg && (CW'(idx_reg) + CW'(1)) >= SeqMax)
                begin
                    rsp_next.batch_full = 1'b1;
                    open_next = '0;
                end
            end
            iftb_pkg::S_DONE:
            begin
                rsp_valid_next = 1'b1;
            end
            default: ;
        endcase
        // Non-batched results are formed as the request leaves the classify step.
        if (state_reg == iftb_pkg::S_ISSUE && !to_lookup)
        begin
            rsp_next = '0;
            rsp_next.disposition    = cls_disp;
            rsp_next.source_changed = src_update;
            if (req_reg.command)
            begin
                open_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iftb_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            open_reg      <= '0;
            last_src_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            open_reg      <= open_next;
            last_src_reg  <= last_src_next;
        end
    end

    // Payload registers: hold the request, scan position and result.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.payload;
        end
        scan_reg    <= scan_next;
        idx_reg     <= idx_next;
        fresh_reg   <= fresh_next;
        changed_reg <= changed_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule

@@ tb/iftb_tb_pkg.sv @@
// Testbench types for the flow batcher bench: the predictor's own state record.
// Depends on iftb_pkg.
package iftb_tb_pkg;

    import iftb_pkg::*;

    localparam int TableDepth = DefMaxSequences;
    localparam int SeqLimit   = DefMaxPacketsPerSeq;

    typedef struct {
        logic [63:0] addr_key  [TableDepth];
        logic [39:0] port_key  [TableDepth];
        int unsigned pkt_count [TableDepth];
        int unsigned open_cnt;
        logic [31:0] last_src;
        logic        ipv4_on;
        logic        icmp_on;
        logic        tcp_on;
        logic        udp_on;
    } flow_state_t;

endpackage

@@ tb/testbench.sv @@
// Self-checking bench for ipv4_flow_tuple_batcher: random stalls on the request and result channels,
// a predictor of classification and sequence batching, and an in-order check.
// Depends on iftb_pkg, iftb_if, iftb_tb_pkg and the batcher RTL.
module testbench;

    import iftb_pkg::*;
    import iftb_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iftb_req_if req_ch ();
    iftb_rsp_if rsp_ch ();
    iftb_cfg_if cfg_ch ();

    ipv4_flow_tuple_batcher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Flip after half a period of two units
    always #1 clk = ~clk;

    req_t        pending_reqs [$];
    rsp_t        expected_rsps [$];
    cfg_t        pending_cfgs [$];
    flow_state_t flows;
    int          fault_count = 0;
    int          idle_cycles = 0;
    int          batched_seen = 0;
    int          fulls_seen = 0;
    int          checked = 0;
    int          req_gap = 0;
    int          rsp_gap = 0;
    bit          drain_done = 1'b0;
    localparam int WatchdogLimit = 20000;

    // Random gap length: mostly short, now and then long, sometimes none
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void wipe_table();
        flows.open_cnt = 0;
    endfunction

    // Predict the single result of one request and advance the flow state
    function automatic rsp_t classify_and_batch(req_t r);
        rsp_t        o;
        logic [17:0] hdr_len;
        logic [63:0] akey;
        logic [39:0] pkey;
        int          slot;
        bit          hit;
        o = '0;
        hit = 1'b0;
        slot = 0;
        hdr_len = {12'd0, r.header_words, 2'b00};
        if (r.command) begin
            wipe_table();
            o.disposition = D_FLUSHED;
            return o;
        end
        if (!flows.ipv4_on) begin
            o.disposition = D_IPV4_OFF;
            return o;
        end
        if (r.ether_type == EthArp) begin
            o.disposition = D_ARP;
            return o;
        end
        if (r.ether_type != EthIpv4) begin
            o.disposition = D_OTHER;
            return o;
        end
        if (hdr_len < MinIpHeader || r.total_length != r.l3_length
                || hdr_len > {2'b00, r.l3_length}) begin
            o.disposition = D_MALFORMED;
            return o;
        end
        if (r.src_addr != 0 && r.src_addr != flows.last_src) begin
            flows.last_src = r.src_addr;
            o.source_changed = 1'b1;
        end
        if (r.protocol == ProtoIcmp) begin
            o.disposition = flows.icmp_on ? D_ICMP : D_ICMP_OFF;
            return o;
        end
        // hdr_len <= l3 here, so the difference cannot wrap
        if ({2'b00, r.l3_length} - hdr_len < L4Header) begin
            o.disposition = D_MALFORMED;
            return o;
        end
        if (r.protocol != ProtoTcp && r.protocol != ProtoUdp) begin
            o.disposition = D_OTHER;
            return o;
        end
        akey = {r.src_addr, r.dst_addr};
        pkey = {r.protocol, r.src_port, r.dst_port};
        // Search newest first; a full match blocks older ones
        for (int k = int'(flows.open_cnt) - 1; k >= 0; k--) begin
            if (flows.addr_key[k] == akey && flows.port_key[k] == pkey) begin
                if (flows.pkt_count[k] < SeqLimit) begin
                    hit = 1'b1;
                    slot = k;
                end
                break;
            end
        end
        if (!hit) begin
            slot = (flows.open_cnt >= TableDepth) ? TableDepth - 1 : flows.open_cnt;
            flows.addr_key[slot] = akey;
            flows.port_key[slot] = pkey;
            flows.pkt_count[slot] = 0;
            flows.open_cnt = slot + 1;
            o.new_sequence = 1'b1;
        end
        flows.pkt_count[slot]++;
        o.seq_index = slot[6:0];
        o.seq_fill = flows.pkt_count[slot][7:0];
        o.deliver = (r.protocol == ProtoTcp) ? flows.tcp_on : flows.udp_on;
        o.disposition = D_BATCHED;
        if (flows.open_cnt >= TableDepth) begin
            o.batch_full = 1'b1;
            wipe_table();
        end
        return o;
    endfunction

    task automatic report(input string what, input rsp_t got, input rsp_t want);
        fault_count++;
        $display("FAULT %s: got %p want %p", what, got, want);
    endtask

    // Driver for requests: pull from the queue, hold until accepted
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.payload <= '0;
            req_gap <= 0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold the request
        end else if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap <= req_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_reqs.pop_front();
            req_gap <= pick_gap();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Prediction at acceptance, in request order
    always @(posedge clk) begin
        if (rst_n && req_ch.valid && req_ch.ready)
            expected_rsps.push_back(classify_and_batch(req_ch.payload));
    end

    // Configuration writes; the predictor takes the value when it is accepted
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.payload <= '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.payload.index)
                    RegIpv4: flows.ipv4_on = cfg_ch.payload.data;
                    RegIcmp: flows.icmp_on = cfg_ch.payload.data;
                    RegTcp:  flows.tcp_on  = cfg_ch.payload.data;
                    RegUdp:  flows.udp_on  = cfg_ch.payload.data;
                    default: ;
                endcase
            end
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (pending_cfgs.size() > 0) begin
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.payload <= pending_cfgs.pop_front();
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_t got;
                rsp_t want;
                got = rsp_ch.payload;
                if (expected_rsps.size() == 0) begin
                    report("unexpected result", got, '0);
                end else begin
                    want = expected_rsps.pop_front();
                    checked++;
                    if (want.disposition == D_BATCHED)
                        batched_seen++;
                    if (want.batch_full)
                        fulls_seen++;
                    if (got.disposition != want.disposition)
                        report("disposition", got, want);
                    if (got.seq_index != want.seq_index)
                        report("seq_index", got, want);
                    if (got.new_sequence != want.new_sequence)
                        report("new_sequence", got, want);
                    if (got.seq_fill != want.seq_fill)
                        report("seq_fill", got, want);
                    if (got.deliver != want.deliver)
                        report("deliver", got, want);
                    if (got.batch_full != want.batch_full)
                        report("batch_full", got, want);
                    if (got.source_changed != want.source_changed)
                        report("source_changed", got, want);
                end
            end
            if (rsp_gap > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_gap <= rsp_gap - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
                rsp_gap <= pick_gap();
            end
        end
    end

    // Watchdog: count cycles with no handshake on any channel
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || drain_done
                || (pending_reqs.size() == 0 && expected_rsps.size() == 0
                    && pending_cfgs.size() == 0 && !req_ch.valid && !cfg_ch.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("ipv4_flow_tuple_batcher: mismatch");
            $finish;
        end
    end

    // Build a well-formed IPv4 frame; proto picks TCP or UDP, or any protocol
    function automatic req_t make_frame(logic [7:0] proto, logic [31:0] sa, logic [31:0] da,
                                        logic [15:0] sp, logic [15:0] dp);
        req_t r;
        r = '0;
        r.ether_type = EthIpv4;
        r.header_words = 4'($urandom_range(5, 15));
        r.l3_length = 16'({r.header_words, 2'b00} + $urandom_range(8, 1500));
        r.total_length = r.l3_length;
        r.protocol = proto;
        r.src_addr = sa;
        r.dst_addr = da;
        r.src_port = sp;
        r.dst_port = dp;
        return r;
    endfunction

    // Random item: mostly flows drawn from a small pool, plus noise and broken headers
    function automatic req_t random_item(int pool);
        req_t        r;
        int          roll;
        int          f;
        logic [7:0]  proto;
        logic [191:0] raw;
        roll = $urandom_range(0, 99);
        f = $urandom_range(0, pool - 1);
        proto = (f % 2) ? ProtoTcp : ProtoUdp;
        r = make_frame(proto, 32'h0a000000 + f, 32'hc0a80000 + f, 16'(1000 + f), 16'(80 + f));
        if (roll < 70)
            return r;
        if (roll < 75) begin
            r = '0;
            r.command = 1'b1;
            r.ether_type = 16'($urandom);
            return r;
        end
        if (roll < 80) begin
            r.ether_type = EthArp;
            return r;
        end
        if (roll < 84) begin
            r.protocol = ProtoIcmp;
            return r;
        end
        if (roll < 88) begin
            r.protocol = 8'($urandom);
            return r;
        end
        if (roll < 92) begin
            r.total_length = 16'($urandom);
            r.header_words = 4'($urandom);
            return r;
        end
        // Fully random fields cover every input bit but the command
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = req_t'(raw[$bits(req_t)-1:0]);
        r.command = 1'b0;
        if ($urandom_range(0, 1))
            r.ether_type = EthIpv4;
        return r;
    endfunction

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic val);
        pending_cfgs.push_back(cfg_t'{index: idx, data: val});
    endtask

    // Wait for every request to come back, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0
                || pending_cfgs.size() > 0 || cfg_ch.valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        req_t r;
        int   pool;
        flows.open_cnt = 0;
        flows.last_src = '0;
        flows.ipv4_on = 1'b1;
        flows.icmp_on = 1'b1;
        flows.tcp_on = 1'b1;
        flows.udp_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every disposition with all enables on, and each corner of the header checks
        r = make_frame(ProtoTcp, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff);
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);
        r = make_frame(ProtoUdp, 32'h0, 32'h0, 16'h0, 16'h0);
        pending_reqs.push_back(r);
        r = make_frame(ProtoIcmp, 32'h01020304, 32'h1, 16'h0, 16'h0);
        pending_reqs.push_back(r);
        r.ether_type = EthArp;
        pending_reqs.push_back(r);
        r.ether_type = 16'hffff;
        pending_reqs.push_back(r);
        r = make_frame(8'hff, 32'h5, 32'h6, 16'h7, 16'h8);
        pending_reqs.push_back(r);
        // Header shorter than twenty bytes
        r = make_frame(ProtoTcp, 32'h9, 32'h9, 16'h9, 16'h9);
        r.header_words = 4'd4;
        pending_reqs.push_back(r);
        // Header longer than the frame
        r.header_words = 4'd15;
        r.l3_length = 16'd56;
        r.total_length = 16'd56;
        pending_reqs.push_back(r);
        // Total length disagrees with the frame
        r = make_frame(ProtoUdp, 32'h9, 32'h9, 16'h9, 16'h9);
        r.total_length = r.total_length + 1;
        pending_reqs.push_back(r);
        // Short L4 header, both for UDP and an unknown protocol; ICMP still passes
        r.header_words = 4'd5;
        r.l3_length = 16'd27;
        r.total_length = 16'd27;
        pending_reqs.push_back(r);
        r.protocol = 8'd50;
        pending_reqs.push_back(r);
        r.protocol = ProtoIcmp;
        r.l3_length = 16'd20;
        r.total_length = 16'd20;
        pending_reqs.push_back(r);
        // Exactly eight bytes of L4 header
        r.protocol = ProtoTcp;
        r.l3_length = 16'd28;
        r.total_length = 16'd28;
        pending_reqs.push_back(r);
        r = '0;
        r.command = 1'b1;
        pending_reqs.push_back(r);
        drain();

        // Full sequence: one flow past its packet limit opens a second slot
        for (int i = 0; i < SeqLimit + 3; i++)
            pending_reqs.push_back(make_frame(ProtoTcp, 32'h11, 32'h22, 16'h33, 16'h44));
        // Table fill: distinct flows until the table wraps
        for (int i = 0; i < TableDepth + 4; i++)
            pending_reqs.push_back(make_frame(ProtoUdp, 32'h100 + i, 32'h200, 16'(i), 16'h1));
        drain();

        // Disabled paths, including end of batch while IPv4 is off
        write_reg(RegIpv4, 1'b0);
        write_reg(RegIcmp, 1'b0);
        write_reg(RegTcp, 1'b0);
        write_reg(RegUdp, 1'b0);
        drain();
        for (int i = 0; i < 30; i++)
            pending_reqs.push_back(random_item(4));
        drain();

        // Random phases across several enable settings, extremes included
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(RegIpv4, (phase != 3));
            write_reg(RegIcmp, phase[0]);
            write_reg(RegTcp, phase[1]);
            write_reg(RegUdp, phase[2] | (phase == 7));
            drain();
            pool = (phase % 2) ? 200 : 6;
            for (int i = 0; i < 120; i++)
                pending_reqs.push_back(random_item(pool));
            drain();
        end

        drain_done = 1'b1;
        $display("checked %0d results: %0d batched, %0d table-full events",
                 checked, batched_seen, fulls_seen);
        if (fault_count == 0)
            $display("ipv4_flow_tuple_batcher: match");
        else
            $display("ipv4_flow_tuple_batcher: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
design/iftb_pkg.sv
design/iftb_if.sv
design/iftb_ram.sv
design/iftb_classify.sv
design/ipv4_flow_tuple_batcher.sv
tb/iftb_tb_pkg.sv
tb/testbench.sv
